[sv/running_median_sorted_insert_macros.svh]
// Assertion macros shared by the running median RTL.
`ifndef RUNNING_MEDIAN_SORTED_INSERT_MACROS_SVH
`define RUNNING_MEDIAN_SORTED_INSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define RMSI_ASSERT_HOLDS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition does not hold");
// Antecedent implies consequent in the same cycle.
`define RMSI_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Antecedent implies consequent in the next cycle.
`define RMSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define RMSI_ASSERT_HOLDS(label, clk, rst, cond)
`define RMSI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RMSI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/rmsi_pkg.sv]
// Types and constants for the running median by sorted insertion.
package rmsi_pkg;

  // Default store depth.
  localparam int RMSI_CAPACITY = 64;

  // Input request payload.
  typedef struct packed {
    logic signed [15:0] sample;
    logic               restart;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic signed [16:0] median_doubled;
    logic [6:0]         stored_count;
    logic               full_res;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the request
    logic rd_scan;     // read store at the scan index
    logic wr_shift;    // move the entry read up by one, step index down
    logic wr_x_above;  // write the sample just above the scan index
    logic wr_x_zero;   // write the sample at the bottom entry
    logic rd_med_a;    // read upper middle entry
    logic rd_med_b;    // read lower middle entry, keep the first
    logic out_load;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;     // store holds nothing after the restart
    logic drop;      // store was full, sample is dropped
    logic ge;        // entry read is greater than or equal to the sample
    logic idx_zero;  // scan index sits at the bottom entry
  } status_t;

endpackage

[sv/rmsi_dp.sv]
// Datapath: sorted sample store, scan index, count and result register.
`include "running_median_sorted_insert_macros.svh"
module rmsi_dp
  import rmsi_pkg::*;
#(
  parameter int CAPACITY = RMSI_CAPACITY
) (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req_data,
  input  cmd_t    cmd,
  output status_t status,
  output rsp_t    rsp_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // Sorted store, ascending.
  logic signed [15:0] mem [CAPACITY];

  logic signed [15:0] x;
  logic signed [15:0] rd_data;
  logic signed [15:0] va;
  logic [CW-1:0]      count;
  logic [AW-1:0]      idx;
  logic               drop;

  logic [CW-1:0]      cnt_eff;
  logic [CW-1:0]      idx_init;
  logic [CW-1:0]      half_w;
  logic [AW-1:0]      half;
  logic [AW-1:0]      second;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [15:0] wr_data;
  logic [CW+6:0]      count_ext;
  logic signed [16:0] sum;

  // Count seen by a new request after an optional restart.
  assign cnt_eff  = req_data.restart ? '0 : count;
  assign idx_init = cnt_eff - CW'(1);

  // Middle entry addresses; for an odd count both reads hit the same entry.
  assign half_w = count >> 1;
  assign half   = half_w[AW-1:0];
  assign second = count[0] ? half : half - AW'(1);

  // Memory port selection.
  assign rd_en   = cmd.rd_scan | cmd.rd_med_a | cmd.rd_med_b;
  assign rd_addr = cmd.rd_scan ? idx : (cmd.rd_med_a ? half : second);
  assign wr_en   = cmd.wr_shift | cmd.wr_x_above | cmd.wr_x_zero;
  assign wr_addr = cmd.wr_x_zero ? '0 : idx + AW'(1);
  assign wr_data = cmd.wr_shift ? rd_data : x;

  // Status back to the controller.
  assign status.empty    = (count == '0);
  assign status.drop     = drop;
  assign status.ge       = (rd_data >= x);
  assign status.idx_zero = (idx == '0);

  // Result arithmetic.
  assign sum       = 17'(va) + 17'(rd_data);
  assign count_ext = {7'd0, count};

  // Store access with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Count and drop flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      drop  <= 1'b0;
    end else if (cmd.load) begin
      count <= cnt_eff;
      drop  <= (cnt_eff == CW'(CAPACITY));
    end else if (cmd.wr_x_above || cmd.wr_x_zero) begin
      count <= count + CW'(1);
    end
  end

  // Sample, scan index, first middle value and result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x   <= req_data.sample;
      idx <= idx_init[AW-1:0];
    end else if (cmd.wr_shift) begin
      idx <= idx - AW'(1);
    end
    if (cmd.rd_med_b) begin
      va <= rd_data;
    end
    if (cmd.out_load) begin
      rsp_data.median_doubled <= sum;
      rsp_data.stored_count   <= count_ext[6:0];
      rsp_data.full_res       <= drop;
    end
  end

  `RMSI_ASSERT_HOLDS(a_count_bound, clk, rst, count <= CW'(CAPACITY))
  `RMSI_ASSERT_IMPL(a_no_insert_on_drop, clk, rst, cmd.wr_x_above || cmd.wr_x_zero, !drop)

endmodule

[sv/rmsi_ctrl.sv]
// Controller: sequences the insertion scan, the median reads and the result.
`include "running_median_sorted_insert_macros.svh"
module rmsi_ctrl
  import rmsi_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_RD     = 3'd2;
  localparam logic [2:0] ST_CMP    = 3'd3;
  localparam logic [2:0] ST_PUT0   = 3'd4;
  localparam logic [2:0] ST_MA     = 3'd5;
  localparam logic [2:0] ST_MB     = 3'd6;
  localparam logic [2:0] ST_MC     = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign req_stall = (state != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.drop) begin
          state_next = ST_MA;
        end else if (status.empty) begin
          state_next = ST_PUT0;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd_scan = 1'b1;
        state_next  = ST_CMP;
      end
      ST_CMP: begin
        if (status.ge) begin
          cmd.wr_shift = 1'b1;
          state_next   = status.idx_zero ? ST_PUT0 : ST_RD;
        end else begin
          cmd.wr_x_above = 1'b1;
          state_next     = ST_MA;
        end
      end
      ST_PUT0: begin
        cmd.wr_x_zero = 1'b1;
        state_next    = ST_MA;
      end
      ST_MA: begin
        cmd.rd_med_a = 1'b1;
        state_next   = ST_MB;
      end
      ST_MB: begin
        cmd.rd_med_b = 1'b1;
        state_next   = ST_MC;
      end
      ST_MC: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `RMSI_ASSERT_NEXT(a_accept_decides, clk, rst, req_valid && !req_stall, state == ST_DECIDE)
  `RMSI_ASSERT_IMPL(a_load_when_free, clk, rst, cmd.out_load, !rsp_valid || !rsp_stall)

endmodule

[sv/running_median_sorted_insert.sv]
// Running median by sorted insertion: each request carries a signed 16-bit
// sample, which is inserted into a sorted store of up to CAPACITY samples
// (a restart flag empties the store first), and each request gives one
// result: twice the median of the stored samples, the stored count, and a
// full flag set when the sample was dropped because the store was full.
// One request is handled at a time. Each stored entry greater than or equal
// to the sample is moved up one place, one entry at a time (read, then
// compare and write back), and the sample is written into the gap, at the
// bottom entry when every stored entry is greater than or equal to it (an
// empty store included); two reads of the middle entries follow. A dropped
// sample skips the scan and the write. While an earlier result still waits
// under output stall, the result load waits too, and the next request is
// accepted once the controller is back in idle after the result is loaded.
// A new request is taken while the previous result still waits on the output.
module running_median_sorted_insert
  import rmsi_pkg::*;
#(
  parameter int CAPACITY = RMSI_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  cmd_t    cmd;
  status_t status;

  // Sequencing.
  rmsi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Store and arithmetic.
  rmsi_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_data (req_data),
    .cmd      (cmd),
    .status   (status),
    .rsp_data (rsp_data)
  );

endmodule
